FILE: design/dti_pkg.sv
// shared types and constants for the diffusion table interpolator
`timescale 1ns / 1ps
`default_nettype none

package dti_pkg;

    localparam int TEMP_W = 32;
    localparam int VAL_W  = 24;
    localparam int IDX_W  = 6;
    localparam int RES_W  = 32;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 7;

    // hbar*c*0.001/(2*pi) in Q.48
    localparam int KW = 34;
    localparam logic [KW-1:0] SCALE_K = 34'd8839880480;

    // magnitude of the line value, split in two halves for the scale multiply
    localparam int MAG_W  = 58;
    localparam int HALF_W = 29;
    localparam int ACC_W  = MAG_W + KW;
    // numerator of the segment division and quotient register
    localparam int DIV1_W = 57;
    localparam int QUO_W  = 58;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_FEW  = 2'd2;
    localparam logic [STAT_W-1:0] ST_SAT  = 2'd3;

    typedef enum logic [2:0] {
        CMD_LOAD,
        CMD_SKIP,
        CMD_FEW,
        CMD_ZERO,
        CMD_QUERY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic [IDX_W-1:0]         idx;
        logic [TEMP_W-1:0]        temp;
        logic signed [VAL_W-1:0]  value;
    } cmd_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_LAST,
        S_CHECK,
        S_SEARCH,
        S_FETCH0,
        S_FETCH1,
        S_FETCH2,
        S_MUL,
        S_PREP1,
        S_DIV1,
        S_INTERP,
        S_MULA,
        S_MULB,
        S_PREP2,
        S_DIV2,
        S_SAT,
        S_FINISH
    } back_state_t;

endpackage

`default_nettype wire

FILE: design/dti_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module dti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: design/dti_front.sv
// front end: config register, item classification and command queue
`timescale 1ns / 1ps
`default_nettype none

module dti_front #(
    parameter int TABLE_POINTS = 64,
    localparam int NW = $clog2(TABLE_POINTS + 1)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       mode,
    input  wire logic [dti_pkg::IDX_W-1:0]  entry_index,
    input  wire logic [dti_pkg::TEMP_W-1:0] temperature,
    input  wire logic signed [dti_pkg::VAL_W-1:0] table_value,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [dti_pkg::CFG_W-1:0]  points_in_use,
    output dti_pkg::cmd_t                   cmd,
    output logic                            cmd_valid,
    input  wire logic                       cmd_pop,
    output logic [NW-1:0]                   n
);

    logic [dti_pkg::CFG_W-1:0] pts_reg;
    dti_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    logic          push;
    logic [31:0]   pts_wide;
    dti_pkg::cmd_t entry;

    assign cfg_ready = 1'b1;
    assign pts_wide  = 32'(pts_reg);
    assign n = (pts_wide > 32'(TABLE_POINTS)) ? NW'(TABLE_POINTS) : NW'(pts_wide);

    always_comb
    begin
        entry.idx   = entry_index;
        entry.temp  = temperature;
        entry.value = table_value;
        if (mode == dti_pkg::MODE_LOAD)
        begin
            entry.kind = (32'(entry_index) < 32'(TABLE_POINTS)) ?
                         dti_pkg::CMD_LOAD : dti_pkg::CMD_SKIP;
        end
        else if (n < NW'(2))
        begin
            entry.kind = dti_pkg::CMD_FEW;
        end
        else if (temperature == '0)
        begin
            entry.kind = dti_pkg::CMD_ZERO;
        end
        else
        begin
            entry.kind = dti_pkg::CMD_QUERY;
        end
    end

    assign in_stall  = (count_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pts_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                pts_reg <= points_in_use;
            end
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= entry;
        end
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> count_reg != 2'd0)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !cmd_pop) |=> count_reg != 2'd0)
        else $error("pushed transfer lost");

endmodule

`default_nettype wire

FILE: design/dti_back.sv
// back end: breakpoint tables, segment search, interpolation and scaling
`timescale 1ns / 1ps
`default_nettype none

module dti_back #(
    parameter int TABLE_POINTS       = 64,
    parameter int TEMP_FRACTION_BITS = 24,
    localparam int NW = $clog2(TABLE_POINTS + 1)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dti_pkg::cmd_t              cmd,
    input  wire logic                       cmd_valid,
    output logic                            cmd_pop,
    input  wire logic [NW-1:0]              n,
    output logic signed [dti_pkg::RES_W-1:0] diffusion_value,
    output logic [dti_pkg::IDX_W-1:0]       segment_used,
    output logic [dti_pkg::STAT_W-1:0]      status,
    output logic                            out_valid,
    input  wire logic                       out_stall
);

    localparam int AW    = $clog2(TABLE_POINTS);
    localparam int TW    = dti_pkg::TEMP_W;
    localparam int VW    = dti_pkg::VAL_W;
    localparam int SHIFT = 48 - TEMP_FRACTION_BITS;
    localparam int DVW   = TW + SHIFT;
    localparam int NMW   = dti_pkg::ACC_W + 1;
    localparam int CW    = $clog2(NMW + 1);
    localparam int QW    = dti_pkg::QUO_W;
    localparam int MW    = dti_pkg::MAG_W;
    localparam int HW    = dti_pkg::HALF_W;
    localparam int PW    = 58;

    dti_pkg::back_state_t state_reg;
    dti_pkg::back_state_t state_next;

    logic [TW-1:0]          temp_reg;
    logic [AW-1:0]          seg_reg;
    logic [TW-1:0]          t0_reg;
    logic [TW-1:0]          t1_reg;
    logic signed [VW-1:0]   v0_reg;
    logic signed [VW-1:0]   v1_reg;
    logic signed [PW-1:0]   p_reg;
    logic signed [TW:0]     dt_reg;
    logic                   neg_reg;
    logic [MW-1:0]          mag_reg;
    logic [dti_pkg::ACC_W-1:0] acc_reg;
    logic [NMW-1:0]         num_reg;
    logic [DVW-1:0]         rem_reg;
    logic [DVW-1:0]         dvs_reg;
    logic [QW-1:0]          quo_reg;
    logic                   ovf_reg;
    logic [CW-1:0]          cnt_reg;
    logic [dti_pkg::RES_W-1:0]  res_val_reg;
    logic [AW-1:0]              res_seg_reg;
    logic [dti_pkg::STAT_W-1:0] res_stat_reg;
    logic                       out_valid_reg;
    logic [dti_pkg::RES_W-1:0]  dv_out_reg;
    logic [dti_pkg::IDX_W-1:0]  seg_out_reg;
    logic [dti_pkg::STAT_W-1:0] stat_out_reg;

    logic [AW-1:0] raddr;
    logic [TW-1:0] rd_temp;
    logic [VW-1:0] rd_val;
    logic          ram_we;
    logic [AW-1:0] nm1;
    logic [AW-1:0] nm2;
    logic          in_range;
    logic          search_go;
    logic          more;
    logic          slot_free;

    logic signed [TW:0]   diff_t;
    logic signed [VW:0]   dv;
    logic signed [PW-1:0] p_abs;
    logic signed [TW:0]   dt_abs;
    logic [dti_pkg::DIV1_W-1:0] num1;
    logic signed [MW:0]   interp;
    logic signed [MW:0]   interp_abs;
    logic [HW-1:0]        mul_a;
    logic [HW+dti_pkg::KW-1:0] mul_p;
    logic [DVW-1:0]       den;
    logic [DVW:0]         shifted;
    logic [DVW:0]         sub;
    logic                 ge;

    assign nm1 = AW'(n - NW'(1));
    assign nm2 = AW'(n - NW'(2));
    assign ram_we = (state_reg == dti_pkg::S_IDLE) && cmd_valid &&
                    (cmd.kind == dti_pkg::CMD_LOAD);

    dti_ram #(.WIDTH(TW), .DEPTH(TABLE_POINTS)) u_temp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(cmd.idx)),
        .wdata (cmd.temp),
        .raddr (raddr),
        .rdata (rd_temp)
    );

    dti_ram #(.WIDTH(VW), .DEPTH(TABLE_POINTS)) u_val_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(cmd.idx)),
        .wdata (cmd.value),
        .raddr (raddr),
        .rdata (rd_val)
    );

    assign in_range  = (temp_reg >= t0_reg) && (temp_reg <= rd_temp);
    assign search_go = temp_reg > rd_temp;
    assign more      = ({1'b0, seg_reg} + (AW+1)'(1)) < {1'b0, nm2};
    assign slot_free = !out_valid_reg || !out_stall;

    // read address is issued one state ahead of the data use
    always_comb
    begin
        raddr = seg_reg;
        unique case (state_reg)
            dti_pkg::S_IDLE:    raddr = '0;
            dti_pkg::S_RD_LAST: raddr = nm1;
            dti_pkg::S_CHECK:   raddr = AW'(1);
            dti_pkg::S_SEARCH:  raddr = seg_reg + AW'(2);
            dti_pkg::S_FETCH0:  raddr = seg_reg;
            dti_pkg::S_FETCH1:  raddr = seg_reg + AW'(1);
            default:            raddr = seg_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        unique case (state_reg)
            dti_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    state_next = (cmd.kind == dti_pkg::CMD_QUERY) ?
                                 dti_pkg::S_RD_LAST : dti_pkg::S_FINISH;
                end
            end
            dti_pkg::S_RD_LAST: state_next = dti_pkg::S_CHECK;
            dti_pkg::S_CHECK:
            begin
                state_next = (in_range && nm2 != '0) ? dti_pkg::S_SEARCH
                                                     : dti_pkg::S_FETCH0;
            end
            dti_pkg::S_SEARCH:
            begin
                state_next = (search_go && more) ? dti_pkg::S_SEARCH
                                                 : dti_pkg::S_FETCH0;
            end
            dti_pkg::S_FETCH0: state_next = dti_pkg::S_FETCH1;
            dti_pkg::S_FETCH1: state_next = dti_pkg::S_FETCH2;
            dti_pkg::S_FETCH2: state_next = dti_pkg::S_MUL;
            dti_pkg::S_MUL:    state_next = dti_pkg::S_PREP1;
            dti_pkg::S_PREP1:
            begin
                state_next = (dt_reg == '0) ? dti_pkg::S_MULA : dti_pkg::S_DIV1;
            end
            dti_pkg::S_DIV1:
            begin
                if (cnt_reg == CW'(1))
                begin
                    state_next = dti_pkg::S_INTERP;
                end
            end
            dti_pkg::S_INTERP: state_next = dti_pkg::S_MULA;
            dti_pkg::S_MULA:   state_next = dti_pkg::S_MULB;
            dti_pkg::S_MULB:   state_next = dti_pkg::S_PREP2;
            dti_pkg::S_PREP2:  state_next = dti_pkg::S_DIV2;
            dti_pkg::S_DIV2:
            begin
                if (cnt_reg == CW'(1))
                begin
                    state_next = dti_pkg::S_SAT;
                end
            end
            dti_pkg::S_SAT:    state_next = dti_pkg::S_FINISH;
            dti_pkg::S_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = dti_pkg::S_IDLE;
                end
            end
            default:           state_next = dti_pkg::S_IDLE;
        endcase
    end

    // datapath helpers
    assign diff_t = $signed({1'b0, temp_reg}) - $signed({1'b0, t0_reg});
    assign dv     = (VW+1)'(v1_reg) - (VW+1)'(v0_reg);
    assign p_abs  = p_reg[PW-1] ? -p_reg : p_reg;
    assign dt_abs = dt_reg[TW] ? -dt_reg : dt_reg;
    assign num1   = p_abs[dti_pkg::DIV1_W-1:0] +
                    dti_pkg::DIV1_W'(dt_abs[TW-1:1]);
    assign interp = neg_reg ? ((MW+1)'(v0_reg) - $signed({1'b0, quo_reg}))
                            : ((MW+1)'(v0_reg) + $signed({1'b0, quo_reg}));
    assign interp_abs = interp[MW] ? -interp : interp;
    assign mul_a  = (state_reg == dti_pkg::S_MULB) ? mag_reg[MW-1:HW] : mag_reg[HW-1:0];
    assign mul_p  = mul_a * dti_pkg::SCALE_K;
    assign den    = DVW'(temp_reg) << SHIFT;
    // one restoring divide step per cycle
    assign shifted = {rem_reg, num_reg[NMW-1]};
    assign sub     = shifted - {1'b0, dvs_reg};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dti_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == dti_pkg::S_FINISH && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            dti_pkg::S_IDLE:
            begin
                temp_reg    <= cmd.temp;
                res_val_reg <= '0;
                res_seg_reg <= '0;
                if (cmd.kind == dti_pkg::CMD_FEW)
                begin
                    res_stat_reg <= dti_pkg::ST_FEW;
                end
                else if (cmd.kind == dti_pkg::CMD_ZERO)
                begin
                    res_stat_reg <= dti_pkg::ST_ZERO;
                end
                else
                begin
                    res_stat_reg <= dti_pkg::ST_OK;
                end
            end
            dti_pkg::S_RD_LAST: t0_reg <= rd_temp;
            dti_pkg::S_CHECK:
            begin
                seg_reg <= (in_range || temp_reg < t0_reg) ? '0 : nm2;
            end
            dti_pkg::S_SEARCH:
            begin
                if (search_go)
                begin
                    seg_reg <= seg_reg + AW'(1);
                end
            end
            dti_pkg::S_FETCH1:
            begin
                t0_reg <= rd_temp;
                v0_reg <= $signed(rd_val);
            end
            dti_pkg::S_FETCH2:
            begin
                t1_reg <= rd_temp;
                v1_reg <= $signed(rd_val);
            end
            dti_pkg::S_MUL:
            begin
                dt_reg <= $signed({1'b0, t1_reg}) - $signed({1'b0, t0_reg});
                p_reg  <= PW'(diff_t) * PW'(dv);
            end
            dti_pkg::S_PREP1:
            begin
                if (dt_reg == '0)
                begin
                    neg_reg <= v0_reg[VW-1];
                    mag_reg <= MW'(v0_reg[VW-1] ? -(MW'(v0_reg)) : MW'(v0_reg));
                end
                else
                begin
                    neg_reg <= p_reg[PW-1] != dt_reg[TW];
                    num_reg <= {num1, (NMW-dti_pkg::DIV1_W)'(0)};
                    dvs_reg <= DVW'(dt_abs[TW-1:0]);
                    rem_reg <= '0;
                    quo_reg <= '0;
                    ovf_reg <= 1'b0;
                    cnt_reg <= CW'(dti_pkg::DIV1_W);
                end
            end
            dti_pkg::S_DIV1, dti_pkg::S_DIV2:
            begin
                rem_reg <= ge ? sub[DVW-1:0] : shifted[DVW-1:0];
                num_reg <= num_reg << 1;
                quo_reg <= {quo_reg[QW-2:0], ge};
                ovf_reg <= ovf_reg | quo_reg[QW-1];
                cnt_reg <= cnt_reg - CW'(1);
            end
            dti_pkg::S_INTERP:
            begin
                neg_reg <= interp[MW];
                mag_reg <= interp_abs[MW-1:0];
            end
            dti_pkg::S_MULA: acc_reg <= dti_pkg::ACC_W'(mul_p);
            dti_pkg::S_MULB:
            begin
                acc_reg <= acc_reg + (dti_pkg::ACC_W'(mul_p) << HW);
            end
            dti_pkg::S_PREP2:
            begin
                num_reg <= NMW'(acc_reg) + NMW'(den >> 1);
                dvs_reg <= den;
                rem_reg <= '0;
                quo_reg <= '0;
                ovf_reg <= 1'b0;
                cnt_reg <= CW'(NMW);
            end
            dti_pkg::S_SAT:
            begin
                res_seg_reg <= seg_reg;
                if (!neg_reg)
                begin
                    if (ovf_reg || quo_reg > QW'(32'h7FFF_FFFF))
                    begin
                        res_val_reg  <= 32'h7FFF_FFFF;
                        res_stat_reg <= dti_pkg::ST_SAT;
                    end
                    else
                    begin
                        res_val_reg <= quo_reg[31:0];
                    end
                end
                else
                begin
                    if (ovf_reg || quo_reg > QW'(32'h8000_0000))
                    begin
                        res_val_reg  <= 32'h8000_0000;
                        res_stat_reg <= dti_pkg::ST_SAT;
                    end
                    else
                    begin
                        res_val_reg <= ~quo_reg[31:0] + 32'd1;
                    end
                end
            end
            dti_pkg::S_FINISH:
            begin
                if (slot_free)
                begin
                    dv_out_reg   <= res_val_reg;
                    seg_out_reg  <= dti_pkg::IDX_W'(res_seg_reg);
                    stat_out_reg <= res_stat_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign diffusion_value = $signed(dv_out_reg);
    assign segment_used    = seg_out_reg;
    assign status          = stat_out_reg;

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dti_pkg::S_DIV1 || state_reg == dti_pkg::S_DIV2) |-> cnt_reg != '0)
        else $error("divider running with zero step count");

    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dti_pkg::S_FINISH && slot_free) |=> out_valid_reg)
        else $error("finished result not presented");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && stat_out_reg == dti_pkg::ST_SAT) |->
        (dv_out_reg == 32'h7FFF_FFFF || dv_out_reg == 32'h8000_0000))
        else $error("saturated status with unclamped value");

endmodule

`default_nettype wire

FILE: design/diffusion_table_interpolator.sv
// top level of the diffusion table interpolator
//
//  channel  direction  handshake             payload
//  in       input      in_valid / in_stall   mode, entry_index, temperature, table_value
//  out      output     out_valid / out_stall diffusion_value, segment_used, status
//  cfg      input      cfg_valid / cfg_ready points_in_use
//
// in a query the back end walks forward through at most n - 2 breakpoints, n being
// points_in_use capped at TABLE_POINTS; its one-bit-per-cycle divider runs 57 steps
// for the segment (skipped for a zero-width segment) and 93 steps for the scaling
// no clearing pass after reset: table entries hold nothing until loaded
// a two-entry command queue keeps taking transfers, until it is full, while the back
// end works or its output register waits on out_stall
`timescale 1ns / 1ps
`default_nettype none

module diffusion_table_interpolator #(
    parameter int TABLE_POINTS       = 64,
    parameter int TEMP_FRACTION_BITS = 24
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        mode,
    input  wire logic [dti_pkg::IDX_W-1:0]   entry_index,
    input  wire logic [dti_pkg::TEMP_W-1:0]  temperature,
    input  wire logic signed [dti_pkg::VAL_W-1:0] table_value,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [dti_pkg::CFG_W-1:0]   points_in_use,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [dti_pkg::RES_W-1:0] diffusion_value,
    output logic [dti_pkg::IDX_W-1:0]        segment_used,
    output logic [dti_pkg::STAT_W-1:0]       status
);

    localparam int NW = $clog2(TABLE_POINTS + 1);

    dti_pkg::cmd_t cmd;
    logic          cmd_valid;
    logic          cmd_pop;
    logic [NW-1:0] n;

    dti_front #(.TABLE_POINTS(TABLE_POINTS)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .entry_index   (entry_index),
        .temperature   (temperature),
        .table_value   (table_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .points_in_use (points_in_use),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop),
        .n             (n)
    );

    dti_back #(
        .TABLE_POINTS       (TABLE_POINTS),
        .TEMP_FRACTION_BITS (TEMP_FRACTION_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cmd_valid       (cmd_valid),
        .cmd_pop         (cmd_pop),
        .n               (n),
        .diffusion_value (diffusion_value),
        .segment_used    (segment_used),
        .status          (status),
        .out_valid       (out_valid),
        .out_stall       (out_stall)
    );

endmodule

`default_nettype wire
